FILE: hdl/wte_pkg.sv
// shared types, constants and operation codes of the watchpoint table engine
`timescale 1ns / 1ps

package wte_pkg;

	localparam int CPU_COUNT     = 8;
	localparam int SLOTS_PER_CPU = 16;
	localparam int CPU_IDX_W     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int SLOT_W        = 5;
	localparam int CFG_W         = 5;
	localparam int FUNC_W        = 3;
	localparam int CPU_W         = 3;
	localparam int ADDR_W        = 32;
	localparam int TAG_W         = 32;
	localparam int MASK_W        = 5;
	localparam int ATYPE_W       = 2;

	localparam logic [MASK_W-1:0] MIN_SHIFT = MASK_W'(3);

	localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DISABLE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_ENABLE  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_HIT     = 3'd5;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [CPU_W-1:0]   cpu;
		logic               cpu_ok;
		logic [SLOT_W-1:0]  n;
		logic [ADDR_W-1:0]  address;
		logic [ATYPE_W-1:0] access_type;
		logic [MASK_W-1:0]  mask_bits;
		logic [TAG_W-1:0]   user_tag;
		logic               has_handler;
	} op_t;

	typedef struct packed {
		logic live;
		logic done;
	} tok_t;

	typedef struct packed {
		logic               handler;
		logic [MASK_W-1:0]  mask;
		logic [ATYPE_W-1:0] atype;
		logic               en;
	} flags_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
	} evt_t;

endpackage

FILE: hdl/wte_cell.sv
// one slot column of the table: the entries of one slot index for every cpu
`timescale 1ns / 1ps

module wte_cell import wte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [SLOT_W-1:0] slot_id,
	input  op_t               op,
	input  tok_t              tok_in,
	output tok_t              tok_out,
	output evt_t              evt
);

	logic              valid_q [CPU_COUNT];
	logic [ADDR_W-1:0] base_q  [CPU_COUNT];
	logic [TAG_W-1:0]  tag_q   [CPU_COUNT];
	flags_t            flags_q [CPU_COUNT];
	tok_t              tok_q;

	logic [CPU_IDX_W-1:0] sel;
	logic                 v;
	logic [ADDR_W-1:0]    b;
	logic [TAG_W-1:0]     t;
	flags_t               fl;
	logic                 act;
	logic                 do_ins;
	logic                 do_rem;
	logic                 do_wipe;
	logic                 do_hit;
	logic                 set_en;
	logic                 clr_en;
	logic [MASK_W-1:0]    sh;
	logic [ADDR_W:0]      hi;
	logic                 in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (step) begin
			tok_q <= tok_in;
		end
	end

	always_comb begin
		sel      = CPU_IDX_W'(op.cpu);
		v        = valid_q[sel];
		b        = base_q[sel];
		t        = tag_q[sel];
		fl       = flags_q[sel];
		act      = tok_q.live && step && op.cpu_ok && (slot_id < op.n);
		sh       = (fl.mask < MIN_SHIFT) ? MIN_SHIFT : fl.mask;
		hi       = {1'b0, b} + ((ADDR_W + 1)'(1) << sh);
		in_range = (op.address >= b) && ({1'b0, op.address} < hi);
		do_ins   = act && (op.func == FN_INSERT) && !tok_q.done && !v;
		do_rem   = act && (op.func == FN_REMOVE) && !tok_q.done && v && (b == op.address);
		do_wipe  = do_rem || (act && (op.func == FN_CLEAR));
		do_hit   = act && (op.func == FN_HIT) && v && fl.handler && in_range;
		set_en   = act && v && ((op.func == FN_ENABLE) || (op.func == FN_HIT));
		clr_en   = act && v && (op.func == FN_DISABLE);
		tok_out.live = tok_q.live;
		tok_out.done = tok_q.done || do_ins || do_rem;
		evt.valid    = do_ins || do_rem || do_hit;
		evt.tag      = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CPU_COUNT; c++) begin
				valid_q[c] <= 1'b0;
			end
		end else if (do_ins) begin
			valid_q[sel] <= 1'b1;
		end else if (do_wipe) begin
			valid_q[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			base_q[sel]  <= op.address;
			tag_q[sel]   <= op.user_tag;
			flags_q[sel] <= '{handler: op.has_handler, mask: op.mask_bits,
				atype: op.access_type, en: 1'b1};
		end else if (do_wipe) begin
			base_q[sel]  <= '0;
			tag_q[sel]   <= '0;
			flags_q[sel] <= '0;
		end else if (set_en) begin
			flags_q[sel].en <= 1'b1;
		end else if (clr_en) begin
			flags_q[sel].en <= 1'b0;
		end
	end

endmodule

FILE: hdl/watchpoint_table_engine.sv
// a token walks the chain of slot cells, one cell per cycle, and stalls while the output is full
// a new request is taken only once the last walk ends; a hit yields up to SLOTS_PER_CPU results
// configuration writes are taken in any cycle
// reset: asynchronous, active low; all entries empty, slot count zero, no result pending
`timescale 1ns / 1ps

module watchpoint_table_engine import wte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   entries_in_use,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [CPU_W-1:0]   cpu,
	input  logic [ADDR_W-1:0]  address,
	input  logic [ATYPE_W-1:0] access_type,
	input  logic [MASK_W-1:0]  mask_bits,
	input  logic [TAG_W-1:0]   user_tag,
	input  logic               has_handler,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SLOT_W-1:0]  slot,
	output logic [TAG_W-1:0]   hit_tag,
	output logic               matched,
	output logic               last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  count_q;
	op_t               op_q;
	logic              pend_v_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [TAG_W-1:0]  pend_tag_q;
	logic              out_v_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              out_m_q;
	logic              out_last_q;

	tok_t tok_in  [SLOTS_PER_CPU];
	tok_t tok_out [SLOTS_PER_CPU];
	evt_t evts    [SLOTS_PER_CPU];
	logic [SLOTS_PER_CPU-1:0] live;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic              step;
	logic              ev_any;
	logic [SLOT_W-1:0] ev_slot;
	logic [TAG_W-1:0]  ev_tag;
	logic              is_hit;
	logic              is_find;
	logic [SLOT_W-1:0] n_eff;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_v_q || out_ready;
	assign step      = accept || ((state_q == ST_RUN) && out_free);
	assign out_load  = ((state_q == ST_RUN) && step && ev_any && pend_v_q)
		|| ((state_q == ST_FIN) && out_free);
	assign is_hit    = (op_q.func == FN_HIT);
	assign is_find   = (op_q.func == FN_INSERT) || (op_q.func == FN_REMOVE) || is_hit;
	assign n_eff     = (count_q > CFG_W'(SLOTS_PER_CPU)) ? SLOT_W'(SLOTS_PER_CPU)
		: SLOT_W'(count_q);

	assign out_valid = out_v_q;
	assign slot      = out_slot_q;
	assign hit_tag   = out_tag_q;
	assign matched   = out_m_q;
	assign last      = out_last_q;

	for (genvar j = 0; j < SLOTS_PER_CPU; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign tok_in[j] = '{live: accept, done: 1'b0};
		end else begin : g_link
			assign tok_in[j] = tok_out[j-1];
		end
		assign live[j] = tok_out[j].live;
		wte_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.slot_id (SLOT_W'(j)),
			.op      (op_q),
			.tok_in  (tok_in[j]),
			.tok_out (tok_out[j]),
			.evt     (evts[j])
		);
	end

	always_comb begin
		ev_any  = 1'b0;
		ev_slot = '0;
		ev_tag  = '0;
		for (int j = 0; j < SLOTS_PER_CPU; j++) begin
			if (evts[j].valid) begin
				ev_any  = 1'b1;
				ev_slot = SLOT_W'(j);
				ev_tag  = evts[j].tag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= entries_in_use;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.func        <= func;
			op_q.cpu         <= cpu;
			op_q.cpu_ok      <= (int'(cpu) < CPU_COUNT);
			op_q.n           <= n_eff;
			op_q.address     <= address;
			op_q.access_type <= access_type;
			op_q.mask_bits   <= mask_bits;
			op_q.user_tag    <= user_tag;
			op_q.has_handler <= has_handler;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_RUN;
						pend_v_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (step) begin
						if (ev_any) begin
							pend_v_q <= 1'b1;
						end
						if (live[SLOTS_PER_CPU-1]) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && step && ev_any) begin
			pend_slot_q <= ev_slot;
			pend_tag_q  <= ev_tag;
			if (pend_v_q) begin
				out_slot_q <= pend_slot_q;
				out_tag_q  <= pend_tag_q;
				out_m_q    <= 1'b1;
				out_last_q <= 1'b0;
			end
		end else if ((state_q == ST_FIN) && out_free) begin
			out_last_q <= 1'b1;
			if (pend_v_q) begin
				out_slot_q <= pend_slot_q;
				out_tag_q  <= is_hit ? pend_tag_q : '0;
				out_m_q    <= is_hit;
			end else begin
				out_slot_q <= is_find ? op_q.n : '0;
				out_tag_q  <= '0;
				out_m_q    <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(live))
		else $error("more than one live token in the chain");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FIN) |-> (live == '0))
		else $error("token in chain outside of a walk");
	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !out_free) |=> $stable(live))
		else $error("chain advanced while output blocked");
	a_single_event: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && ev_any) |-> step)
		else $error("cell event without a chain step");
`endif

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the watchpoint table engine, directed and random requests
`timescale 1ns / 1ps

module tb_top import wte_pkg::*; ();

	localparam int TABLE_SIZE  = CPU_COUNT * SLOTS_PER_CPU;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 2 * (SLOTS_PER_CPU + 2);
	localparam int PRINT_CAP   = 40;

	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		logic              matched;
		logic              last;
	} wp_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   entries_in_use = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [FUNC_W-1:0]  func = '0;
	logic [CPU_W-1:0]   cpu = '0;
	logic [ADDR_W-1:0]  address = '0;
	logic [ATYPE_W-1:0] access_type = '0;
	logic [MASK_W-1:0]  mask_bits = '0;
	logic [TAG_W-1:0]   user_tag = '0;
	logic               has_handler = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SLOT_W-1:0]  slot;
	logic [TAG_W-1:0]   hit_tag;
	logic               matched;
	logic               last;

	// mirror of the watchpoint store
	logic              wp_valid [TABLE_SIZE];
	flags_t            wp_flags [TABLE_SIZE];
	logic [ADDR_W-1:0] wp_base  [TABLE_SIZE];
	logic [TAG_W-1:0]  wp_tag   [TABLE_SIZE];
	int unsigned       slot_count = 0;

	wp_result_t        due_results [$];
	logic [ADDR_W-1:0] recent_bases [$];

	bit long_hold = 1'b0;
	bit calm = 1'b0;
	int n_errors = 0;
	int n_sent = 0;
	int n_results = 0;
	int n_settings = 0;
	int max_burst = 0;
	int stall_cycles = 0;

	watchpoint_table_engine u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.entries_in_use (entries_in_use),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.cpu            (cpu),
		.address        (address),
		.access_type    (access_type),
		.mask_bits      (mask_bits),
		.user_tag       (user_tag),
		.has_handler    (has_handler),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.slot           (slot),
		.hit_tag        (hit_tag),
		.matched        (matched),
		.last           (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void table_apply(input logic [FUNC_W-1:0] f, input logic [CPU_W-1:0] c,
			input logic [ADDR_W-1:0] a, input logic [ATYPE_W-1:0] at,
			input logic [MASK_W-1:0] m, input logic [TAG_W-1:0] t, input logic h);
		int unsigned n;
		int unsigned first;
		int unsigned i;
		int unsigned sh;
		int hits;
		bit ok;
		bit found;
		bit have_pending;
		logic [ADDR_W:0] lo;
		logic [ADDR_W:0] hi;
		wp_result_t r;
		wp_result_t pending;
		n = (slot_count > SLOTS_PER_CPU) ? SLOTS_PER_CPU : slot_count;
		ok = (int'(c) < CPU_COUNT);
		first = ok ? int'(c) * SLOTS_PER_CPU : 0;
		found = 1'b0;
		hits = 0;
		have_pending = 1'b0;
		pending = '0;
		r = '0;
		r.last = 1'b1;
		case (f)
			FN_INSERT: begin
				r.slot = SLOT_W'(n);
				for (i = 0; ok && i < n; i++) begin
					if (!found && !wp_valid[first + i]) begin
						wp_valid[first + i] = 1'b1;
						wp_base[first + i] = a;
						wp_tag[first + i] = t;
						wp_flags[first + i] = '{handler: h, mask: m, atype: at, en: 1'b1};
						r.slot = SLOT_W'(i);
						found = 1'b1;
					end
				end
				due_results.push_back(r);
			end
			FN_REMOVE: begin
				r.slot = SLOT_W'(n);
				for (i = 0; ok && i < n; i++) begin
					if (!found && wp_valid[first + i] && wp_base[first + i] == a) begin
						wp_valid[first + i] = 1'b0;
						wp_base[first + i] = '0;
						wp_tag[first + i] = '0;
						wp_flags[first + i] = '0;
						r.slot = SLOT_W'(i);
						found = 1'b1;
					end
				end
				due_results.push_back(r);
			end
			FN_CLEAR, FN_DISABLE, FN_ENABLE: begin
				for (i = 0; ok && i < n; i++) begin
					if (f == FN_CLEAR) begin
						wp_valid[first + i] = 1'b0;
						wp_base[first + i] = '0;
						wp_tag[first + i] = '0;
						wp_flags[first + i] = '0;
					end else if (wp_valid[first + i]) begin
						wp_flags[first + i].en = (f == FN_ENABLE);
					end
				end
				due_results.push_back(r);
			end
			FN_HIT: begin
				for (i = 0; ok && i < n; i++) begin
					if (wp_valid[first + i] && wp_flags[first + i].handler) begin
						sh = 32'(wp_flags[first + i].mask);
						if (sh < 32'(MIN_SHIFT))
							sh = 32'(MIN_SHIFT);
						lo = {1'b0, wp_base[first + i]};
						hi = lo + ((ADDR_W + 1)'(1) << sh);
						if ({1'b0, a} >= lo && {1'b0, a} < hi) begin
							if (have_pending)
								due_results.push_back(pending);
							pending = '{slot: SLOT_W'(i), tag: wp_tag[first + i],
								matched: 1'b1, last: 1'b0};
							have_pending = 1'b1;
							hits++;
						end
					end
				end
				for (i = 0; ok && i < n; i++) begin
					if (wp_valid[first + i])
						wp_flags[first + i].en = 1'b1;
				end
				if (have_pending) begin
					pending.last = 1'b1;
					due_results.push_back(pending);
				end else begin
					r.slot = SLOT_W'(n);
					due_results.push_back(r);
				end
				if (hits > max_burst)
					max_burst = hits;
			end
			default: begin
				due_results.push_back(r);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= PRINT_CAP)
			$display("mismatch at %0t ns, result %0d: %s got 0x%0h expected 0x%0h",
				$time, n_results, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		wp_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (due_results.size() == 0) begin
				report_mismatch("result with no request pending, slot", 32'(slot), 32'h0);
			end else begin
				want = due_results.pop_front();
				if (slot !== want.slot)
					report_mismatch("slot", 32'(slot), 32'(want.slot));
				if (hit_tag !== want.tag)
					report_mismatch("hit_tag", hit_tag, want.tag);
				if (matched !== want.matched)
					report_mismatch("matched", 32'(matched), 32'(want.matched));
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				stall_cycles, due_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : out_ready_drive
		int gap;
		int hold_cycles;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < LONG_HOLD) begin
					@(posedge clk);
					hold_cycles++;
				end
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 6);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [CPU_W-1:0] c,
			input logic [ADDR_W-1:0] a, input logic [ATYPE_W-1:0] at,
			input logic [MASK_W-1:0] m, input logic [TAG_W-1:0] t, input logic h);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		cpu <= c;
		address <= a;
		access_type <= at;
		mask_bits <= m;
		user_tag <= t;
		has_handler <= h;
		do @(posedge clk); while (!in_ready);
		table_apply(f, c, a, at, m, t, h);
		if (f == FN_INSERT) begin
			recent_bases.push_back(a);
			if (recent_bases.size() > 24)
				void'(recent_bases.pop_front());
		end
		n_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		entries_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slot_count = 32'(v);
		n_settings++;
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5 && recent_bases.size() != 0)
			return recent_bases[$urandom_range(0, recent_bases.size() - 1)];
		case (pick % 4)
			0: return 32'h0000_0000 + ADDR_W'($urandom_range(0, 255));
			1: return 32'h0000_1000 + ADDR_W'($urandom_range(0, 4095));
			2: return 32'hFFFF_FF00 + ADDR_W'($urandom_range(0, 255));
			default: return ADDR_W'($urandom);
		endcase
	endfunction

	task automatic send_random(input int cpu_hi);
		logic [FUNC_W-1:0] f;
		logic [ADDR_W-1:0] a;
		logic [MASK_W-1:0] m;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			f = FN_INSERT;
		else if (pick < 48)
			f = FN_REMOVE;
		else if (pick < 84)
			f = FN_HIT;
		else if (pick < 88)
			f = FN_CLEAR;
		else if (pick < 92)
			f = FN_DISABLE;
		else if (pick < 96)
			f = FN_ENABLE;
		else if (pick < 98)
			f = FN_SPARE_A;
		else
			f = FN_SPARE_B;
		a = pick_address();
		if (f == FN_HIT && $urandom_range(0, 3) != 0)
			a = a + ADDR_W'($urandom_range(0, 300));
		if ($urandom_range(0, 3) == 0)
			m = MASK_W'($urandom_range(0, 31));
		else
			m = MASK_W'($urandom_range(0, 10));
		send_req(f, CPU_W'($urandom_range(0, cpu_hi)), a, ATYPE_W'($urandom_range(0, 3)), m,
			TAG_W'($urandom), $urandom_range(0, 4) != 0);
	endtask

	task automatic test_reset_count();
		// slot count still zero: every table looks full and empty at once
		send_req(FN_INSERT, 3'd0, 32'h0000_0040, 2'd3, 5'd4, 32'hDEAD_BEEF, 1'b1);
		send_req(FN_HIT, 3'd0, 32'h0000_0040, 2'd0, 5'd0, 32'h0, 1'b0);
	endtask

	task automatic test_each_operation();
		// count above table size saturates
		write_slot_count(5'd31);
		send_req(FN_INSERT, 3'd7, 32'h0000_0000, 2'd0, 5'd0, 32'h0000_0000, 1'b1);
		send_req(FN_INSERT, 3'd7, 32'hFFFF_FFF8, 2'd3, 5'd31, 32'hFFFF_FFFF, 1'b1);
		send_req(FN_INSERT, 3'd7, 32'h0000_1000, 2'd1, 5'd4, 32'h1234_5678, 1'b0);
		send_req(FN_INSERT, 3'd7, 32'h0000_1000, 2'd2, 5'd12, 32'hA5A5_A5A5, 1'b1);
		send_req(FN_INSERT, 3'd7, 32'h0000_0000, 2'd1, 5'd31, 32'h5A5A_5A5A, 1'b1);
		// minimum range of eight bytes, edges of the window, compare without wrap
		send_req(FN_HIT, 3'd7, 32'h0000_0000, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'h0000_0007, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'h0000_0008, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'h0000_1004, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'hFFFF_FFFF, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'h8000_0000, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_DISABLE, 3'd7, 32'h0, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'h0000_1FFF, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_ENABLE, 3'd7, 32'h0, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_REMOVE, 3'd7, 32'h0000_1000, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_REMOVE, 3'd7, 32'h0000_1000, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_REMOVE, 3'd7, 32'h0000_1000, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_INSERT, 3'd7, 32'h0000_2000, 2'd2, 5'd3, 32'h0BAD_F00D, 1'b1);
		send_req(FN_SPARE_A, 3'd7, 32'hFFFF_FFFF, 2'd3, 5'd31, 32'hFFFF_FFFF, 1'b1);
		send_req(FN_SPARE_B, 3'd7, 32'h0000_2000, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_CLEAR, 3'd7, 32'h0, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd7, 32'h0000_0000, 2'd0, 5'd0, 32'h0, 1'b0);
	endtask

	task automatic test_single_slot();
		write_slot_count(5'd1);
		send_req(FN_INSERT, 3'd3, 32'h0000_0100, 2'd1, 5'd8, 32'h0000_0001, 1'b1);
		send_req(FN_INSERT, 3'd3, 32'h0000_0200, 2'd2, 5'd8, 32'h0000_0002, 1'b1);
		send_req(FN_HIT, 3'd3, 32'h0000_01FF, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_REMOVE, 3'd3, 32'h0000_0200, 2'd0, 5'd0, 32'h0, 1'b0);
	endtask

	task automatic test_full_table_hit();
		int i;
		write_slot_count(5'd16);
		send_req(FN_CLEAR, 3'd2, 32'h0, 2'd0, 5'd0, 32'h0, 1'b0);
		for (i = 0; i < SLOTS_PER_CPU; i++)
			send_req(FN_INSERT, 3'd2, 32'h8000_0000 + ADDR_W'($urandom_range(0, 255)),
				ATYPE_W'($urandom_range(0, 3)), MASK_W'($urandom_range(9, 31)),
				TAG_W'($urandom), 1'b1);
		send_req(FN_INSERT, 3'd2, 32'h8000_0000, 2'd3, 5'd9, 32'h0, 1'b1);
		send_req(FN_HIT, 3'd2, 32'h8000_0100, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_DISABLE, 3'd2, 32'h0, 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_HIT, 3'd2, 32'h8000_0000 + ADDR_W'($urandom_range(0, 1023)),
			2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_REMOVE, 3'd2, recent_bases[$urandom_range(0, 15)], 2'd0, 5'd0, 32'h0, 1'b0);
		send_req(FN_INSERT, 3'd2, 32'h8000_00F0, 2'd1, 5'd20, TAG_W'($urandom), 1'b1);
		send_req(FN_HIT, 3'd2, 32'h8000_0100, 2'd0, 5'd0, 32'h0, 1'b0);
	endtask

	task automatic test_random_mix();
		int i;
		write_slot_count(5'd16);
		for (i = 0; i < 22; i++)
			send_random(1);
	endtask

	task automatic test_small_tables();
		int i;
		write_slot_count(CFG_W'($urandom_range(1, 5)));
		for (i = 0; i < 20; i++)
			send_random(1);
		write_slot_count(CFG_W'($urandom_range(0, 31)));
		for (i = 0; i < 20; i++)
			send_random(3);
	endtask

	task automatic test_output_backpressure();
		int i;
		write_slot_count(5'd16);
		long_hold = 1'b1;
		for (i = 0; i < 16; i++)
			send_random(1);
	endtask

	task automatic test_no_idle();
		int i;
		calm = 1'b1;
		write_slot_count(CFG_W'($urandom_range(17, 31)));
		for (i = 0; i < 40; i++)
			send_random(7);
	endtask

	initial begin
		int i;
		for (i = 0; i < TABLE_SIZE; i++) begin
			wp_valid[i] = 1'b0;
			wp_flags[i] = '0;
			wp_base[i] = '0;
			wp_tag[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_each_operation();
		test_single_slot();
		test_full_table_hit();
		test_random_mix();
		test_small_tables();
		test_output_backpressure();
		test_no_idle();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d requests and %0d results over %0d slot-count settings",
			n_sent, n_results, n_settings);
		$display("largest hit burst %0d entries, %0d mismatches", max_burst, n_errors);
		if (n_errors == 0 && due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/wte_pkg.sv
hdl/wte_cell.sv
hdl/watchpoint_table_engine.sv
tb/tb_top.sv
